[rtl/multi_stack_shared_pool_assert.svh]
// ============================================================================
// multi_stack_shared_pool_assert.svh
// Assertion macros shared by the shared-pool stack block.
// ============================================================================
`ifndef MULTI_STACK_SHARED_POOL_ASSERT_SVH
`define MULTI_STACK_SHARED_POOL_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MSP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("msp assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("msp assertion failed");

`endif

[rtl/msp_pkg.sv]
// ============================================================================
// msp_pkg
// Shared types and constants of the shared-pool stack block.
// ============================================================================
package msp_pkg;

    // Default sizes of the block.
    localparam int NUM_STACKS_DEF = 4;
    localparam int POOL_SLOTS_DEF = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Operation codes carried by the mode field.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take the item and start the pool reads
        logic commit;   // update the lists and load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // result register can be loaded this cycle
    } sts_t;

endpackage

[rtl/msp_ctrl.sv]
// ============================================================================
// msp_ctrl
// Controller of the shared-pool stack block: sequences read and commit.
// ============================================================================
module msp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  msp_pkg::sts_t  sts,
    output msp_pkg::cmd_t  cmd
);

    msp_pkg::state_t state_reg;
    msp_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            msp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = msp_pkg::ST_EXEC;
                end
            end
            msp_pkg::ST_EXEC: begin
                // Hold the item until the result register has room.
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = msp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = msp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/msp_dp.sv]
// ============================================================================
// msp_dp
// Datapath of the shared-pool stack block: pool memories, list heads and
// the result register.
// ============================================================================
module msp_dp #(
    parameter int NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
    parameter int POOL_SLOTS = msp_pkg::POOL_SLOTS_DEF,
    parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_mode,
    input  logic [1:0]          s_stack_select,
    input  logic signed [31:0]  s_push_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic signed [31:0]  m_pop_value,
    input  msp_pkg::cmd_t       cmd,
    output msp_pkg::sts_t       sts
);

    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);
    localparam int SEL_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    // Pool memories; a link is {valid, slot index}.
    logic [DATA_WIDTH-1:0] value_mem [POOL_SLOTS];
    logic [IDX_W:0]        link_mem  [POOL_SLOTS];

    // Stack heads and free-list head.
    logic [IDX_W-1:0] head_idx_reg [NUM_STACKS];
    logic             head_vld_reg [NUM_STACKS];
    logic [IDX_W-1:0] free_idx_reg;
    logic             free_vld_reg;

    // Slots below this count have had their link written at least once.
    logic [CNT_W-1:0] fill_reg;

    // Item held between capture and commit.
    logic                  op_mode_reg;
    logic [SEL_W-1:0]      op_sel_reg;
    logic                  op_ok_reg;
    logic [IDX_W-1:0]      op_slot_reg;
    logic [DATA_WIDTH-1:0] op_value_reg;

    // Registered pool read data.
    logic [DATA_WIDTH-1:0] value_rd_reg;
    logic [IDX_W:0]        link_rd_reg;
    logic                  fresh_rd_reg;

    // Result register.
    logic                  m_valid_reg;
    logic [1:0]            m_status_reg;
    logic signed [31:0]    m_pop_value_reg;

    logic                  sel_in_range;
    logic [SEL_W-1:0]      sel_idx;
    logic                  sel_head_vld;
    logic [IDX_W-1:0]      sel_head_idx;
    logic [IDX_W-1:0]      cap_slot;
    logic                  cap_ok;
    logic [IDX_W:0]        init_link;
    logic [IDX_W:0]        next_link;
    logic signed [31:0]    pop_ext;
    msp_pkg::status_t      status_code;

    // Stack selection and the slot that this item addresses.
    assign sel_in_range = int'(s_stack_select) < NUM_STACKS;
    assign sel_idx      = SEL_W'(s_stack_select);
    assign sel_head_vld = sel_in_range ? head_vld_reg[sel_idx] : 1'b0;
    assign sel_head_idx = sel_in_range ? head_idx_reg[sel_idx] : '0;
    assign cap_slot     = (s_mode == msp_pkg::MODE_POP) ? sel_head_idx : free_idx_reg;
    assign cap_ok       = sel_in_range &&
                          ((s_mode == msp_pkg::MODE_POP) ? sel_head_vld : free_vld_reg);

    // Capture the item.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_mode_reg  <= s_mode;
            op_sel_reg   <= sel_idx;
            op_ok_reg    <= cap_ok;
            op_slot_reg  <= cap_slot;
            op_value_reg <= DATA_WIDTH'($unsigned(s_push_value));
        end
    end

    // Pool reads, started at capture.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            value_rd_reg <= value_mem[cap_slot];
            link_rd_reg  <= link_mem[cap_slot];
            fresh_rd_reg <= CNT_W'(cap_slot) >= fill_reg;
        end
    end

    // A never-written link is read as its initial value: the next slot.
    assign init_link = {op_slot_reg != IDX_W'(POOL_SLOTS - 1), op_slot_reg + IDX_W'(1)};
    assign next_link = fresh_rd_reg ? init_link : link_rd_reg;

    // Pool writes at commit.
    always_ff @(posedge aclk) begin
        if (cmd.commit && op_ok_reg) begin
            if (op_mode_reg == msp_pkg::MODE_PUSH) begin
                value_mem[op_slot_reg] <= op_value_reg;
                link_mem[op_slot_reg]  <= {head_vld_reg[op_sel_reg], head_idx_reg[op_sel_reg]};
            end else begin
                link_mem[op_slot_reg]  <= {free_vld_reg, free_idx_reg};
            end
        end
    end

    // List heads and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                head_vld_reg[i] <= 1'b0;
            end
            free_idx_reg <= '0;
            free_vld_reg <= 1'b1;
            fill_reg     <= '0;
        end else if (cmd.commit && op_ok_reg) begin
            if (op_mode_reg == msp_pkg::MODE_PUSH) begin
                head_idx_reg[op_sel_reg] <= op_slot_reg;
                head_vld_reg[op_sel_reg] <= 1'b1;
                free_idx_reg             <= next_link[IDX_W-1:0];
                free_vld_reg             <= next_link[IDX_W];
                if (CNT_W'(op_slot_reg) == fill_reg) begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end else begin
                head_idx_reg[op_sel_reg] <= next_link[IDX_W-1:0];
                head_vld_reg[op_sel_reg] <= next_link[IDX_W];
                free_idx_reg             <= op_slot_reg;
                free_vld_reg             <= 1'b1;
            end
        end
    end

    // Result fields.
    assign pop_ext = 32'($signed(value_rd_reg));

    always_comb begin
        if (op_ok_reg) begin
            status_code = msp_pkg::STATUS_DONE;
        end else if (op_mode_reg == msp_pkg::MODE_POP) begin
            status_code = msp_pkg::STATUS_EMPTY;
        end else begin
            status_code = msp_pkg::STATUS_FULL;
        end
    end

    // Result register: loaded at commit, freed when the item is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status_reg    <= status_code;
            m_pop_value_reg <= (op_ok_reg && op_mode_reg == msp_pkg::MODE_POP) ? pop_ext : '0;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_pop_value  = m_pop_value_reg;

endmodule

[rtl/multi_stack_shared_pool.sv]
// ============================================================================
// multi_stack_shared_pool
// Several LIFO stacks sharing one pool of slots through a linked free list.
// ============================================================================
// Usage:
// Each input item (s_mode, s_stack_select, s_push_value) is a push or a pop
// on one stack and gives exactly one result item (m_status, m_pop_value).
// A push takes the head of the free list and links it on top of the stack;
// it answers full when no slot is free. A pop unlinks the top slot, returns
// it to the free list and gives its value; it answers empty on an empty or
// nonexistent stack. Both channels use valid/ready handshakes.
// The accepting edge reads the slot's link and value from the pool memories;
// the commit edge, which waits while the result register is still full,
// writes the lists back and loads the result register. No new item is
// accepted until the current one has committed.
// A new item is accepted while a finished result waits; if the receiver
// still stalls when the next result is ready, that item waits in the
// commit step and s_ready stays low until the result register frees.
// Reset (aresetn low, synchronous) empties all stacks and links every slot
// into the free list in order at once; no clearing pass is needed.
// ============================================================================
`include "multi_stack_shared_pool_assert.svh"

module multi_stack_shared_pool #(
    parameter int NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
    parameter int POOL_SLOTS = msp_pkg::POOL_SLOTS_DEF,
    parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [1:0]         s_stack_select,
    input  logic signed [31:0] s_push_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_pop_value
);

    msp_pkg::cmd_t cmd;
    msp_pkg::sts_t sts;

    // Controller.
    msp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath.
    msp_dp #(
        .NUM_STACKS (NUM_STACKS),
        .POOL_SLOTS (POOL_SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_mode         (s_mode),
        .s_stack_select (s_stack_select),
        .s_push_value   (s_push_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_pop_value    (m_pop_value),
        .cmd            (cmd),
        .sts            (sts)
    );

    // An accepted item blocks the input for the following cycle.
    `MSP_ASSERT_NEXT(a_accept_then_busy, aclk, aresetn, s_valid && s_ready, !s_ready)

    // Capture and commit never fall in the same cycle.
    `MSP_ASSERT_NOW(a_capture_commit_apart, aclk, aresetn, cmd.capture, !cmd.commit)

    // A commit always leaves a result on the output.
    `MSP_ASSERT_NEXT(a_commit_gives_result, aclk, aresetn, cmd.commit, m_valid)

    // A commit happens only when the result register has room.
    `MSP_ASSERT_NOW(a_commit_has_room, aclk, aresetn, cmd.commit, !m_valid || m_ready)

endmodule
